// ----- sv/bmi_pkg.sv -----
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared constants, types and constant functions for the body motion step.
// ----------------------------------------------------------------------------
`default_nettype none

package bmi_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int DT_W   = 16;
	localparam int FR_W   = 17;
	localparam int GR_W   = 31;
	localparam int MS_W   = 31;
	localparam int GDT_W  = 32;
	localparam int MSQ_W  = 2 * MS_W;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 31;
	localparam int LANES  = 3;

	localparam logic [CFG_AW-1:0] CFG_DELTA_TIME  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_FRICTION    = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_GRAVITY     = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_MAX_SPEED   = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_USE_GRAVITY = 3'd4;

	localparam logic [DT_W-1:0] DT_RST = 16'd1092;
	localparam logic [FR_W-1:0] FR_RST = 17'd65536;
	localparam logic [GR_W-1:0] GR_RST = 31'd642253;
	localparam logic [MS_W-1:0] MS_RST = 31'h7FFF_FFFF;
	localparam logic [FR_W-1:0] F_ONE  = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MSQ,
		ST_LOG,
		ST_T1,
		ST_T2,
		ST_EXP,
		ST_FIN
	} drag_state_t;

	typedef struct packed {
		logic              busy;
		logic [FR_W-1:0]   f;
		logic [GDT_W-1:0]  gdt;
		logic [MS_W-1:0]   ms;
		logic [MSQ_W-1:0]  mssq;
	} drag_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bv;
		rem = v;
		res = 64'd0;
		bv  = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bv > v) bv = bv >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bv != 64'd0) begin
				if (rem >= res + bv) begin
					rem = rem - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		end
		return res;
	endfunction

	// Q1.30 value of 2^(-2^-k), by repeated root
	function automatic logic [30:0] exp_root(input int k);
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) begin
			if (i <= k) c = isqrt64(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

`default_nettype wire

// ----- sv/body_motion_integrate_step.sv -----
// ----------------------------------------------------------------------------
// body_motion_integrate_step
// Front stages feed one-bit-per-stage root and divide pipelines, then the back
// stages; one word per cycle while the output is not stalled, the drag sequencer is
// idle and no settings write is under way. After reset and after every settings
// write the drag sequencer runs its log squarings and exp products with input held.
// Reset clears valids and loads the settings defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module body_motion_integrate_step #(
	parameter int VALUE_WIDTH = bmi_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = bmi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// vel_in_x, vel_in_y, vel_in_z, acc_x, acc_y, acc_z, pos_in_x, pos_in_y, pos_in_z
	input  wire logic [((9*VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// grounded_in
	input  wire logic                                   s_axis_tuser,
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// vel_out_x, vel_out_y, vel_out_z, pos_out_x, pos_out_y, pos_out_z
	output logic [((6*VALUE_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
	// grounded_out
	output logic                                        m_axis_tuser,
	input  wire logic                                   cfg_we,
	input  wire logic [bmi_pkg::CFG_AW-1:0]             cfg_addr,
	input  wire logic [bmi_pkg::CFG_DW-1:0]             cfg_wdata
);

	localparam int W    = VALUE_WIDTH;
	localparam int OTW  = ((6*VALUE_WIDTH+7)/8)*8;
	localparam int XW   = ((W > 32) ? W : 32) + 2;
	localparam int SQ   = (W > 32) ? W - 32 : 0;
	localparam int UW   = (W > 32) ? 32 : W;
	localparam int SW   = 2 * UW + 2;
	localparam int RW   = UW + 1;
	localparam int QW   = bmi_pkg::MS_W;
	localparam int NW   = RW + QW;
	localparam int PW   = UW + bmi_pkg::MS_W;
	localparam int CW   = (SW > bmi_pkg::MSQ_W) ? SW : bmi_pkg::MSQ_W;

	localparam logic signed [XW-1:0] VMAX_X = $signed(XW'({(W-1){1'b1}}));
	localparam logic signed [XW-1:0] VMIN_X = -VMAX_X - XW'(1);
	localparam logic [W-1:0]         ONE    = W'(1) << FRAC_BITS;

	typedef struct packed {
		logic                g;
		logic [2:0][W-1:0]   p;
	} carry_t;

	typedef struct packed {
		logic                g;
		logic                over;
		logic [2:0][UW-1:0]  u;
		logic [2:0][W-1:0]   v;
		logic [2:0][W-1:0]   p;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + W'(1)) : x;
	endfunction

	function automatic logic [W:0] mulr_mag(input logic [W-1:0] m,
			input logic [bmi_pkg::FR_W-1:0] k);
		logic [W+16:0] pr;
		pr = (W+17)'(m) * (W+17)'(k) + (W+17)'(32768);
		return pr[W+16:16];
	endfunction

	function automatic logic signed [XW-1:0] sx(input logic [W-1:0] x);
		return XW'($signed(x));
	endfunction

	function automatic logic signed [XW-1:0] sgn_x(input logic [W:0] m, input logic neg);
		logic signed [XW-1:0] t;
		t = $signed(XW'(m));
		return neg ? -t : t;
	endfunction

	function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] x);
		if (x > VMAX_X) return W'(VMAX_X);
		if (x < VMIN_X) return W'(VMIN_X);
		return x[W-1:0];
	endfunction

	// settings
	logic [bmi_pkg::DT_W-1:0] dt_q;
	logic [bmi_pkg::FR_W-1:0] fr_q;
	logic [bmi_pkg::GR_W-1:0] gr_q;
	logic [bmi_pkg::MS_W-1:0] ms_q;
	logic                     ug_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= bmi_pkg::DT_RST;
			fr_q <= bmi_pkg::FR_RST;
			gr_q <= bmi_pkg::GR_RST;
			ms_q <= bmi_pkg::MS_RST;
			ug_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				bmi_pkg::CFG_DELTA_TIME:  dt_q <= cfg_wdata[bmi_pkg::DT_W-1:0];
				bmi_pkg::CFG_FRICTION:    fr_q <= cfg_wdata[bmi_pkg::FR_W-1:0];
				bmi_pkg::CFG_GRAVITY:     gr_q <= cfg_wdata[bmi_pkg::GR_W-1:0];
				bmi_pkg::CFG_MAX_SPEED:   ms_q <= cfg_wdata[bmi_pkg::MS_W-1:0];
				bmi_pkg::CFG_USE_GRAVITY: ug_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	bmi_pkg::drag_t drag;

	bmi_drag #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_drag (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.dt        (dt_q),
		.friction  (fr_q),
		.gravity   (gr_q),
		.max_speed (ms_q),
		.drag      (drag)
	);

	logic en;
	logic dtnz;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign dtnz          = (dt_q != '0);
	assign s_axis_tready = en && !drag.busy && !cfg_we;

	logic [2:0][W-1:0] vin, ain, pin;
	assign vin = s_axis_tdata[3*W-1:0];
	assign ain = s_axis_tdata[6*W-1:3*W];
	assign pin = s_axis_tdata[9*W-1:6*W];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;
	logic sq_vld, dv_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			{vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14} <= '0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid && s_axis_tready;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= sq_vld;
			vld_s10 <= vld_s9;
			vld_s11 <= dv_vld;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// front: acceleration, drag, gravity, squares
	logic [2:0][W-1:0]  v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [2:0][W:0]    am_s1, vm_s3;
	logic [2:0]         an_s1, vn_s3;
	carry_t             cr_s1, cr_s2, cr_s3, cr_s4, cr_s5, cr_s6, cr_s7, cr_s8;
	logic [2:0][UW-1:0] u_s6, u_s7, u_s8;
	logic [2:0][2*UW-1:0] sq_s6;
	logic [SW-1:0]      sum_s7, sum_s8;
	logic               over_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s1 <= '{g: s_axis_tuser, p: pin};
			cr_s2 <= cr_s1;
			cr_s3 <= cr_s2;
			cr_s4 <= cr_s3;
			cr_s5 <= cr_s4;
			cr_s6 <= cr_s5;
			cr_s7 <= cr_s6;
			cr_s8 <= cr_s7;
			v_s1  <= vin;
			for (int i = 0; i < 3; i++) begin
				am_s1[i] <= mulr_mag(mag(ain[i]), bmi_pkg::FR_W'(dt_q));
				an_s1[i] <= ain[i][W-1];
				v_s2[i]  <= sat_w(sx(v_s1[i]) + sgn_x(am_s1[i], an_s1[i]));
				vm_s3[i] <= mulr_mag(mag(v_s2[i]), drag.f);
				vn_s3[i] <= v_s2[i][W-1];
				v_s4[i]  <= sat_w(sgn_x(vm_s3[i], vn_s3[i]));
				u_s6[i]  <= UW'(mag(v_s5[i]) >> SQ);
				sq_s6[i] <= (2*UW)'(UW'(mag(v_s5[i]) >> SQ)) *
					(2*UW)'(UW'(mag(v_s5[i]) >> SQ));
			end
			v_s5[0] <= v_s4[0];
			v_s5[2] <= v_s4[2];
			v_s5[1] <= (ug_q && !cr_s4.g) ?
				sat_w(sx(v_s4[1]) - $signed(XW'(drag.gdt))) : v_s4[1];
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			u_s7    <= u_s6;
			sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			v_s8    <= v_s7;
			u_s8    <= u_s7;
			sum_s8  <= sum_s7;
			over_s8 <= dtnz && (CW'(sum_s7) > CW'(drag.mssq));
		end
	end

	side_t side_s8, sq_side, dv_side, side_s9, side_s10;
	assign side_s8 = '{g: cr_s8.g, over: over_s8, u: u_s8, v: v_s8, p: cr_s8.p};

	logic [RW-1:0] sq_root;

	bmi_sqrt_pipe #(
		.IW     (SW),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.in_val   (sum_s8),
		.in_side  (side_s8),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	logic [PW-1:0] prod_s9 [3];
	logic [RW-1:0] s_s9, s_s10;
	logic [NW-1:0] num_s10 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s9     <= sq_root;
			side_s9  <= sq_side;
			s_s10    <= s_s9;
			side_s10 <= side_s9;
			for (int i = 0; i < 3; i++) begin
				prod_s9[i] <= PW'(sq_side.u[i]) * PW'(drag.ms);
				num_s10[i] <= NW'(prod_s9[i]) + NW'(s_s9 >> 1);
			end
		end
	end

	logic [QW-1:0] dv_quo [3];

	bmi_div_pipe #(
		.NW     (NW),
		.DW     (RW),
		.QW     (QW),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s10),
		.in_num   (num_s10),
		.in_den   (s_s10),
		.in_side  (side_s10),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// back: limit, position advance, ground clamp
	logic [2:0][W-1:0] vl_s11, vl_s12, vl_s13, v_s14;
	logic [2:0][W-1:0] p_s13, p_s14;
	logic [2:0][W:0]   pm_s12;
	logic [2:0]        pn_s12;
	carry_t            cr_s11, cr_s12;
	logic              g_s13, g_s14;
	logic signed [XW-1:0] lim_c [3];
	logic              clamp_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lim_c[i] = $signed(XW'(dv_quo[i]) << SQ);
			if (dv_side.v[i][W-1]) lim_c[i] = -lim_c[i];
		end
	end

	assign clamp_c = dtnz && ug_q && ($signed(p_s13[1]) < $signed(ONE));

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s11 <= '{g: dv_side.g, p: dv_side.p};
			cr_s12 <= cr_s11;
			vl_s12 <= vl_s11;
			vl_s13 <= vl_s12;
			g_s13  <= cr_s12.g;
			for (int i = 0; i < 3; i++) begin
				vl_s11[i] <= dv_side.over ? sat_w(lim_c[i]) : dv_side.v[i];
				pm_s12[i] <= mulr_mag(mag(vl_s11[i]), bmi_pkg::FR_W'(dt_q));
				pn_s12[i] <= vl_s11[i][W-1];
				p_s13[i]  <= sat_w(sx(cr_s12.p[i]) + sgn_x(pm_s12[i], pn_s12[i]));
			end
			v_s14 <= clamp_c ? {vl_s13[2], {W{1'b0}}, vl_s13[0]} : vl_s13;
			p_s14 <= clamp_c ? {p_s13[2], ONE, p_s13[0]} : p_s13;
			g_s14 <= g_s13 || clamp_c;
		end
	end

	assign m_axis_tvalid = vld_s14;
	assign m_axis_tdata  = OTW'({p_s14, v_s14});
	assign m_axis_tuser  = g_s14;

endmodule

`default_nettype wire

// ----- sv/bmi_drag.sv -----
// ----------------------------------------------------------------------------
// bmi_drag
// Sequencer for the settings-derived factors: drag factor, gravity step,
// scaled speed limit and its square.
// ----------------------------------------------------------------------------
`default_nettype none

module bmi_drag #(
	parameter int VALUE_WIDTH = bmi_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bmi_pkg::DT_W-1:0]    dt,
	input  wire logic [bmi_pkg::FR_W-1:0]    friction,
	input  wire logic [bmi_pkg::GR_W-1:0]    gravity,
	input  wire logic [bmi_pkg::MS_W-1:0]    max_speed,
	output bmi_pkg::drag_t                   drag
);

	localparam int SQ = (VALUE_WIDTH > 32) ? VALUE_WIDTH - 32 : 0;

	bmi_pkg::drag_state_t state_q, state_d;

	logic [30:0] ck_tab [16];

	for (genvar j = 0; j < 16; j++) begin : g_ck
		localparam logic [30:0] CKV = bmi_pkg::exp_root(j + 1);
		assign ck_tab[j] = CKV;
	end

	logic [3:0]  cnt_q;
	logic        one_q, zero_q;
	logic [30:0] m_q;
	logic [4:0]  lgi_q;
	logic [15:0] frac_q;
	logic [21:0] dt60_q;
	logic [20:0] lg_q;
	logic [27:0] t_q;
	logic [30:0] acc_q;
	logic [bmi_pkg::FR_W-1:0]  f_q;
	logic [bmi_pkg::GDT_W-1:0] gdt_q;
	logic [bmi_pkg::MS_W-1:0]  ms_q;
	logic [bmi_pkg::MSQ_W-1:0] mssq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmi_pkg::ST_PREP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmi_pkg::ST_IDLE: state_d = bmi_pkg::ST_IDLE;
			bmi_pkg::ST_PREP: state_d = bmi_pkg::ST_MSQ;
			bmi_pkg::ST_MSQ:  state_d = bmi_pkg::ST_LOG;
			bmi_pkg::ST_LOG:  if (cnt_q == 4'd15) state_d = bmi_pkg::ST_T1;
			bmi_pkg::ST_T1:   state_d = bmi_pkg::ST_T2;
			bmi_pkg::ST_T2:   state_d = bmi_pkg::ST_EXP;
			bmi_pkg::ST_EXP:  if (cnt_q == 4'd15) state_d = bmi_pkg::ST_FIN;
			bmi_pkg::ST_FIN:  state_d = bmi_pkg::ST_IDLE;
			default:          state_d = bmi_pkg::ST_IDLE;
		endcase
		if (cfg_we) state_d = bmi_pkg::ST_PREP;
	end

	// prep: clip friction, find leading one; products for the other states
	logic [16:0] fr_c;
	logic [3:0]  lead_c;
	logic [46:0] gp_c;
	logic [61:0] sqp_c;
	logic [61:0] ep_c;
	logic [42:0] tp_c;
	logic [4:0]  n_c;
	logic [47:0] fin_c;

	always_comb begin
		fr_c = (friction > bmi_pkg::F_ONE) ? bmi_pkg::F_ONE : friction;
		lead_c = 4'd0;
		for (int b = 0; b < 16; b++) begin
			if (fr_c[b]) lead_c = 4'(b);
		end
		gp_c  = 47'(gravity) * 47'(dt) + 47'd32768;
		sqp_c = 62'(m_q) * 62'(m_q);
		ep_c  = 62'(acc_q) * 62'(ck_tab[cnt_q]) + (62'd1 << 29);
		tp_c  = 43'(dt60_q) * 43'(lg_q) + 43'd32768;
		n_c   = t_q[20:16];
		fin_c = (48'(acc_q) + (48'd1 << (5'd13 + n_c))) >> (5'd14 + n_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (state_q == bmi_pkg::ST_LOG || state_q == bmi_pkg::ST_EXP) begin
			cnt_q <= cnt_q + 4'd1;
		end else begin
			cnt_q <= 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bmi_pkg::ST_PREP: begin
				one_q  <= (dt == '0) || fr_c[16];
				zero_q <= (fr_c == '0);
				m_q    <= 31'(fr_c[15:0]) << (5'd30 - 5'(lead_c));
				lgi_q  <= 5'd16 - 5'(lead_c);
				frac_q <= '0;
				gdt_q  <= bmi_pkg::GDT_W'(gp_c[46:16]);
				ms_q   <= bmi_pkg::MS_W'(max_speed >> SQ);
			end
			bmi_pkg::ST_MSQ: begin
				mssq_q <= bmi_pkg::MSQ_W'(ms_q) * bmi_pkg::MSQ_W'(ms_q);
			end
			bmi_pkg::ST_LOG: begin
				if (sqp_c[61]) begin
					m_q    <= sqp_c[61:31];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sqp_c[60:30];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			bmi_pkg::ST_T1: begin
				dt60_q <= 22'(dt) * 22'd60;
				lg_q   <= {lgi_q, 16'd0} - 21'(frac_q);
			end
			bmi_pkg::ST_T2: begin
				t_q   <= tp_c[42:16] ;
				acc_q <= 31'd1 << 30;
			end
			bmi_pkg::ST_EXP: begin
				if (t_q[4'd15 - cnt_q]) acc_q <= ep_c[60:30];
			end
			bmi_pkg::ST_FIN: begin
				if (one_q) begin
					f_q <= bmi_pkg::F_ONE;
				end else if (zero_q || t_q >= (28'd17 << 16)) begin
					f_q <= '0;
				end else begin
					f_q <= fin_c[16:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		drag.busy = (state_q != bmi_pkg::ST_IDLE);
		drag.f    = f_q;
		drag.gdt  = gdt_q;
		drag.ms   = ms_q;
		drag.mssq = mssq_q;
	end

endmodule

`default_nettype wire

// ----- sv/bmi_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// bmi_sqrt_pipe
// Integer square root, one result bit per pipeline stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmi_sqrt_pipe #(
	parameter int IW     = 66,
	parameter int SIDE_W = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_vld,
	input  wire logic [IW-1:0]       in_val,
	input  wire logic [SIDE_W-1:0]   in_side,
	output logic                     out_vld,
	output logic [IW/2-1:0]          out_root,
	output logic [SIDE_W-1:0]        out_side
);

	localparam int RW = IW / 2;

	logic              vld_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [RW+1:0]     rem_s  [RW];
	logic [IW-1:0]     x_s    [RW];
	logic [SIDE_W-1:0] side_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_st
		logic              vld_i;
		logic [RW-1:0]     root_i;
		logic [RW+1:0]     rem_i;
		logic [IW-1:0]     x_i;
		logic [SIDE_W-1:0] side_i;
		logic [RW+3:0]     remx;
		logic [RW+3:0]     trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign vld_i  = in_vld;
			assign root_i = '0;
			assign rem_i  = '0;
			assign x_i    = in_val;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[j-1];
			assign root_i = root_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign x_i    = x_s[j-1];
			assign side_i = side_s[j-1];
		end

		assign remx  = {rem_i, x_i[IW-1:IW-2]};
		assign trial = (RW+4)'({root_i, 2'b01});
		assign ge    = (remx >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? (RW+2)'(remx - trial) : (RW+2)'(remx);
				root_s[j] <= {root_i[RW-2:0], ge};
				x_s[j]    <= x_i << 2;
				side_s[j] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_side = side_s[RW-1];

endmodule

`default_nettype wire

// ----- sv/bmi_div_pipe.sv -----
// ----------------------------------------------------------------------------
// bmi_div_pipe
// Restoring divider, three lanes sharing one divisor, one quotient bit per
// pipeline stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmi_div_pipe #(
	parameter int NW     = 64,
	parameter int DW     = 33,
	parameter int QW     = 31,
	parameter int SIDE_W = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_vld,
	input  wire logic [NW-1:0]       in_num [bmi_pkg::LANES],
	input  wire logic [DW-1:0]       in_den,
	input  wire logic [SIDE_W-1:0]   in_side,
	output logic                     out_vld,
	output logic [QW-1:0]            out_quo [bmi_pkg::LANES],
	output logic [SIDE_W-1:0]        out_side
);

	localparam int L = bmi_pkg::LANES;

	logic              vld_s  [QW];
	logic [DW-1:0]     den_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];
	logic [DW-1:0]     rem_s  [QW][L];
	logic [QW-1:0]     n_s    [QW][L];
	logic [QW-1:0]     q_s    [QW][L];

	for (genvar j = 0; j < QW; j++) begin : g_st
		logic              vld_i;
		logic [DW-1:0]     den_i;
		logic [SIDE_W-1:0] side_i;

		if (j == 0) begin : g_first
			assign vld_i  = in_vld;
			assign den_i  = in_den;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[j-1];
			assign den_i  = den_s[j-1];
			assign side_i = side_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= den_i;
				side_s[j] <= side_i;
			end
		end

		for (genvar l = 0; l < L; l++) begin : g_lane
			logic [DW-1:0] rem_i;
			logic [QW-1:0] n_i;
			logic [QW-1:0] q_i;
			logic [DW:0]   remx;
			logic          ge;

			if (j == 0) begin : g_first
				assign rem_i = in_num[l][NW-1:QW];
				assign n_i   = in_num[l][QW-1:0];
				assign q_i   = '0;
			end else begin : g_next
				assign rem_i = rem_s[j-1][l];
				assign n_i   = n_s[j-1][l];
				assign q_i   = q_s[j-1][l];
			end

			assign remx = {rem_i, n_i[QW-1]};
			assign ge   = (remx >= (DW+1)'(den_i));

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j][l] <= ge ? DW'(remx - (DW+1)'(den_i)) : DW'(remx);
					n_s[j][l]   <= n_i << 1;
					q_s[j][l]   <= {q_i[QW-2:0], ge};
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < L; l++) begin
			out_quo[l] = q_s[QW-1][l];
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule

`default_nettype wire
